@@ rtl/brlc_pkg.sv @@
`default_nettype none

package brlc_pkg;

    localparam int unsigned NUM_LANES     = 8;
    localparam int unsigned OUT_LANES_DEF = 8;
    localparam int unsigned LIT_BYTES     = 4;

    localparam logic [7:0] MAX_RUN = 8'd255;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_EXPAND = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_MALFORMED = 1'b1;

    // one queued job: either up to four literal bytes or a repeated byte
    typedef struct packed {
        logic [LIT_BYTES-1:0][7:0] lit;
        logic                      rep;
        logic [7:0]                value;
        logic [7:0]                count;
        logic                      stream_end;
        logic                      status;
    } brlc_desc_t;

endpackage

`default_nettype wire

@@ rtl/brlc_front.sv @@
`default_nettype none

module brlc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_codec_mode,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_byte_present,
    input  wire logic              s_end_of_stream,
    output logic                   q_push,
    output brlc_pkg::brlc_desc_t   q_desc,
    input  wire logic              q_ready
);
    import brlc_pkg::*;

    logic       mode_reg, mode_next;
    logic [7:0] run_byte_reg, run_byte_next;
    logic [7:0] run_length_reg, run_length_next;
    logic [7:0] pending_count_reg, pending_count_next;
    logic       count_held_reg, count_held_next;
    logic       error_seen_reg, error_seen_next;

    logic       accept;
    logic       pair_out;
    logic       flush;
    logic       fault_now;
    logic [7:0] byte_new, len_new, pend_new;
    logic       held_new, err_new;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign accept    = s_valid && q_ready;

    always_comb begin
        byte_new  = run_byte_reg;
        len_new   = run_length_reg;
        pend_new  = pending_count_reg;
        held_new  = count_held_reg;
        err_new   = error_seen_reg;
        pair_out  = 1'b0;
        flush     = 1'b0;
        fault_now = 1'b0;
        q_desc    = '0;

        if (mode_reg == MODE_ENCODE) begin
            if (s_byte_present) begin
                if (run_length_reg == 8'd0) begin
                    byte_new = s_data_byte;
                    len_new  = 8'd1;
                end else if (s_data_byte == run_byte_reg && run_length_reg < MAX_RUN) begin
                    len_new = run_length_reg + 8'd1;
                end else begin
                    pair_out = 1'b1;
                    byte_new = s_data_byte;
                    len_new  = 8'd1;
                end
            end
            flush = s_end_of_stream && (len_new != 8'd0);
            // held pair goes first, the flushed run after it
            q_desc.lit[0] = pair_out ? run_length_reg : len_new;
            q_desc.lit[1] = pair_out ? run_byte_reg : byte_new;
            q_desc.lit[2] = len_new;
            q_desc.lit[3] = byte_new;
            q_desc.count  = (pair_out ? 8'd2 : 8'd0) + (flush ? 8'd2 : 8'd0);
        end else begin
            if (s_byte_present && !error_seen_reg) begin
                if (!count_held_reg) begin
                    if (s_data_byte == 8'd0) begin
                        err_new   = 1'b1;
                        fault_now = 1'b1;
                    end else begin
                        pend_new = s_data_byte;
                        held_new = 1'b1;
                    end
                end else begin
                    q_desc.rep   = 1'b1;
                    q_desc.value = s_data_byte;
                    q_desc.count = pending_count_reg;
                    pend_new     = 8'd0;
                    held_new     = 1'b0;
                end
            end
            // lone count byte at end of stream
            if (s_end_of_stream && held_new && !err_new) begin
                err_new = 1'b1;
            end
        end

        q_desc.stream_end = s_end_of_stream;
        q_desc.status     = (mode_reg == MODE_EXPAND && err_new) ? STATUS_MALFORMED
                                                                 : STATUS_OK;
        q_push = accept && (q_desc.count != 8'd0 || s_end_of_stream || fault_now);
    end

    always_comb begin
        mode_next          = mode_reg;
        run_byte_next      = run_byte_reg;
        run_length_next    = run_length_reg;
        pending_count_next = pending_count_reg;
        count_held_next    = count_held_reg;
        error_seen_next    = error_seen_reg;
        if (accept) begin
            if (s_end_of_stream) begin
                run_byte_next      = 8'd0;
                run_length_next    = 8'd0;
                pending_count_next = 8'd0;
                count_held_next    = 1'b0;
                error_seen_next    = 1'b0;
            end else begin
                run_byte_next      = byte_new;
                run_length_next    = len_new;
                pending_count_next = pend_new;
                count_held_next    = held_new;
                error_seen_next    = err_new;
            end
        end
        if (cfg_valid) begin
            mode_next          = cfg_codec_mode;
            run_byte_next      = 8'd0;
            run_length_next    = 8'd0;
            pending_count_next = 8'd0;
            count_held_next    = 1'b0;
            error_seen_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_ENCODE;
            run_byte_reg      <= 8'd0;
            run_length_reg    <= 8'd0;
            pending_count_reg <= 8'd0;
            count_held_reg    <= 1'b0;
            error_seen_reg    <= 1'b0;
        end else begin
            mode_reg          <= mode_next;
            run_byte_reg      <= run_byte_next;
            run_length_reg    <= run_length_next;
            pending_count_reg <= pending_count_next;
            count_held_reg    <= count_held_next;
            error_seen_reg    <= error_seen_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/brlc_queue.sv @@
`default_nettype none

module brlc_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire brlc_pkg::brlc_desc_t in_desc,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output brlc_pkg::brlc_desc_t      out_desc
);
    import brlc_pkg::*;

    // two-entry shift queue, head always in the first slot
    brlc_desc_t head_reg, head_next;
    brlc_desc_t tail_reg, tail_next;
    logic       head_vld_reg, head_vld_next;
    logic       tail_vld_reg, tail_vld_next;
    logic       push, pop;

    assign in_ready  = !tail_vld_reg;
    assign out_valid = head_vld_reg;
    assign out_desc  = head_reg;
    assign push      = in_valid && !tail_vld_reg;
    assign pop       = head_vld_reg && out_ready;

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        head_vld_next = head_vld_reg;
        tail_vld_next = tail_vld_reg;
        if (pop) begin
            head_next     = tail_vld_reg ? tail_reg : in_desc;
            head_vld_next = tail_vld_reg || push;
            tail_next     = in_desc;
            tail_vld_next = tail_vld_reg && push;
        end else if (push) begin
            if (!head_vld_reg) begin
                head_next     = in_desc;
                head_vld_next = 1'b1;
            end else begin
                tail_next     = in_desc;
                tail_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (!aresetn) begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
        end else begin
            head_vld_reg <= head_vld_next;
            tail_vld_reg <= tail_vld_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/brlc_back.sv @@
`default_nettype none

module brlc_back #(
    parameter int unsigned OUT_LANES = brlc_pkg::OUT_LANES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  q_valid,
    output logic                                       q_pop,
    input  wire brlc_pkg::brlc_desc_t                  q_desc,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [brlc_pkg::NUM_LANES-1:0][7:0]        m_lanes,
    output logic [3:0]                                 m_valid_bytes,
    output logic                                       m_last_of_item,
    output logic                                       m_stream_end,
    output logic                                       m_status
);
    import brlc_pkg::*;

    brlc_desc_t                  cur_reg;
    logic                        cur_vld_reg, cur_vld_next;
    logic [7:0]                  rem_reg, rem_next;
    logic [2:0]                  pos_reg, pos_next;

    logic                        m_valid_reg, m_valid_next;
    logic [NUM_LANES-1:0][7:0]   lanes_reg, lanes_next;
    logic [3:0]                  vbytes_reg;
    logic                        last_reg, end_reg, status_reg;

    logic                        out_free, emit, last_word;
    logic [7:0]                  n_word;
    logic [NUM_LANES-1:0][1:0]   lit_idx;
    logic [NUM_LANES-1:0][2:0]   lit_sum;

    assign out_free  = !m_valid_reg || m_ready;
    assign q_pop     = !cur_vld_reg && q_valid;
    assign emit      = cur_vld_reg && out_free;
    assign last_word = rem_reg <= 8'(OUT_LANES);
    assign n_word    = last_word ? rem_reg : 8'(OUT_LANES);

    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            lit_sum[j] = pos_reg + 3'(j);
            lit_idx[j] = lit_sum[j][1:0];
            if (8'(j) < n_word) begin
                lanes_next[j] = cur_reg.rep ? cur_reg.value : cur_reg.lit[lit_idx[j]];
            end else begin
                lanes_next[j] = 8'd0;
            end
        end
    end

    always_comb begin
        cur_vld_next = cur_vld_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            cur_vld_next = 1'b1;
            rem_next     = q_desc.count;
            pos_next     = 3'd0;
        end else if (emit) begin
            m_valid_next = 1'b1;
            rem_next     = rem_reg - n_word;
            pos_next     = pos_reg + n_word[2:0];
            if (last_word) begin
                cur_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_desc;
        end
        rem_reg <= rem_next;
        pos_reg <= pos_next;
        if (emit) begin
            lanes_reg  <= lanes_next;
            vbytes_reg <= n_word[3:0];
            last_reg   <= last_word;
            end_reg    <= last_word && cur_reg.stream_end;
            status_reg <= cur_reg.status;
        end
        if (!aresetn) begin
            cur_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_vld_reg <= cur_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_lanes        = lanes_reg;
    assign m_valid_bytes  = vbytes_reg;
    assign m_last_of_item = last_reg;
    assign m_stream_end   = end_reg;
    assign m_status       = status_reg;

endmodule

`default_nettype wire

@@ rtl/byte_run_length_codec_core.sv @@
// channel | direction | beat carries                               | handshake
// cfg     | in        | codec_mode                                 | cfg_valid / cfg_ready
// s       | in        | data_byte, byte_present, end_of_stream     | s_valid / s_ready
// m       | out       | lane0..7, valid_bytes, last_of_item,       | m_valid / m_ready
//         |           | stream_end, status                         |
//
// a beat that yields results is first loaded into the word builder, which then emits one
// output word per cycle while the output is not stalled by m_ready: one word in compress
// mode at 8 lanes, ceil(count/OUT_LANES) words in expand mode (up to 32 for a count of 255).
// beats that yield no result stay in the front end and push nothing into the queue.
// synchronous active-low reset clears the mode register, the stream state, the queue
// and the word builder.
// a two-entry queue between classifier and word builder lets either side stall alone.
`default_nettype none

module byte_run_length_codec_core #(
    parameter int unsigned OUT_LANES = brlc_pkg::OUT_LANES_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_codec_mode,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_byte_present,
    input  wire logic       s_end_of_stream,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_lane0,
    output logic [7:0]      m_lane1,
    output logic [7:0]      m_lane2,
    output logic [7:0]      m_lane3,
    output logic [7:0]      m_lane4,
    output logic [7:0]      m_lane5,
    output logic [7:0]      m_lane6,
    output logic [7:0]      m_lane7,
    output logic [3:0]      m_valid_bytes,
    output logic            m_last_of_item,
    output logic            m_stream_end,
    output logic            m_status
);
    import brlc_pkg::*;

    logic                      push, push_ready;
    brlc_desc_t                push_desc;
    logic                      q_valid, q_pop;
    brlc_desc_t                q_desc;
    logic [NUM_LANES-1:0][7:0] lanes;

    brlc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_codec_mode  (cfg_codec_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_byte_present  (s_byte_present),
        .s_end_of_stream (s_end_of_stream),
        .q_push          (push),
        .q_desc          (push_desc),
        .q_ready         (push_ready)
    );

    brlc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (push_ready),
        .in_desc   (push_desc),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_desc  (q_desc)
    );

    brlc_back #(
        .OUT_LANES (OUT_LANES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_desc         (q_desc),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lanes        (lanes),
        .m_valid_bytes  (m_valid_bytes),
        .m_last_of_item (m_last_of_item),
        .m_stream_end   (m_stream_end),
        .m_status       (m_status)
    );

    assign m_lane0 = lanes[0];
    assign m_lane1 = lanes[1];
    assign m_lane2 = lanes[2];
    assign m_lane3 = lanes[3];
    assign m_lane4 = lanes[4];
    assign m_lane5 = lanes[5];
    assign m_lane6 = lanes[6];
    assign m_lane7 = lanes[7];

    // only the closing word of a beat may be partly filled
    a_full_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_item |-> m_valid_bytes == 4'(OUT_LANES))
        else $error("non-final word not full");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> m_last_of_item)
        else $error("stream end on a non-final word");

    a_lane_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_valid_bytes <= 4'(OUT_LANES))
        else $error("valid_bytes exceeds lane count");

    // a dropped push would lose a whole beat of results
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> push_ready)
        else $error("queue push while full");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brlc_pkg::*;

    localparam int unsigned LANES         = OUT_LANES_DEF;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          DRAIN_LIMIT   = 50000;
    localparam int          MAX_PRINTS    = 30;
    localparam int          HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [7:0][7:0] lanes;
        logic [3:0]      nbytes;
        logic            last;
        logic            send;
        logic            stat;
    } rle_word_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_codec_mode;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_byte_present;
    logic       s_end_of_stream;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_lane0, m_lane1, m_lane2, m_lane3;
    logic [7:0] m_lane4, m_lane5, m_lane6, m_lane7;
    logic [3:0] m_valid_bytes;
    logic       m_last_of_item;
    logic       m_stream_end;
    logic       m_status;

    // predicted codec state
    logic       pred_mode;
    logic [7:0] run_val;
    logic [7:0] run_len;
    logic [7:0] cnt_pending;
    logic       cnt_held;
    logic       err_seen;

    rle_word_t  expected_words[$];
    rle_word_t  exp_w;
    rle_word_t  got_w;

    int err_count    = 0;
    int results_seen = 0;
    int beats_sent   = 0;
    int mode_writes  = 0;
    int rx_hold_len  = 0;
    bit idle_on      = 1'b1;

    byte_run_length_codec_core #(
        .OUT_LANES(LANES)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_codec_mode (cfg_codec_mode),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_end_of_stream(s_end_of_stream),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lane0        (m_lane0),
        .m_lane1        (m_lane1),
        .m_lane2        (m_lane2),
        .m_lane3        (m_lane3),
        .m_lane4        (m_lane4),
        .m_lane5        (m_lane5),
        .m_lane6        (m_lane6),
        .m_lane7        (m_lane7),
        .m_valid_bytes  (m_valid_bytes),
        .m_last_of_item (m_last_of_item),
        .m_stream_end   (m_stream_end),
        .m_status       (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("run did not finish in time");
        $display("byte_run_length_codec_core regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     results_seen, what, want, got);
        end
    endtask

    function automatic int draw_gap();
        if (!idle_on || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic void clear_stream_state();
        run_val     = 8'd0;
        run_len     = 8'd0;
        cnt_pending = 8'd0;
        cnt_held    = 1'b0;
        err_seen    = 1'b0;
    endfunction

    // expected output words for one accepted input beat
    task automatic predict_beat(input logic [7:0] data, input logic present, input logic eos);
        logic [7:0] obytes[$];
        logic       fault_now;
        logic       stat;
        int         nwords;
        int         pos;
        rle_word_t  w;
        fault_now = 1'b0;
        if (present) begin
            if (pred_mode == MODE_ENCODE) begin
                if (run_len == 8'd0) begin
                    run_val = data;
                    run_len = 8'd1;
                end else if (data == run_val && run_len < MAX_RUN) begin
                    run_len = run_len + 8'd1;
                end else begin
                    obytes.push_back(run_len);
                    obytes.push_back(run_val);
                    run_val = data;
                    run_len = 8'd1;
                end
            end else if (!err_seen) begin
                if (!cnt_held) begin
                    if (data == 8'd0) begin
                        err_seen  = 1'b1;
                        fault_now = 1'b1;
                    end else begin
                        cnt_pending = data;
                        cnt_held    = 1'b1;
                    end
                end else begin
                    repeat (cnt_pending) obytes.push_back(data);
                    cnt_pending = 8'd0;
                    cnt_held    = 1'b0;
                end
            end
        end
        if (eos) begin
            if (pred_mode == MODE_ENCODE) begin
                if (run_len != 8'd0) begin
                    obytes.push_back(run_len);
                    obytes.push_back(run_val);
                end
            end else if (cnt_held) begin
                // stream closed on a count with no value
                err_seen = 1'b1;
            end
        end
        stat   = (pred_mode == MODE_EXPAND) && err_seen;
        nwords = (obytes.size() + LANES - 1) / LANES;
        if (nwords == 0 && (eos || fault_now)) begin
            nwords = 1;
        end
        pos = 0;
        for (int k = 0; k < nwords; k++) begin
            w = '0;
            for (int j = 0; j < LANES && pos < obytes.size(); j++) begin
                w.lanes[j] = obytes[pos];
                w.nbytes   = w.nbytes + 4'd1;
                pos++;
            end
            w.last = (k == nwords - 1);
            w.send = eos && w.last;
            w.stat = stat;
            expected_words.push_back(w);
        end
        if (eos) begin
            clear_stream_state();
        end
    endtask

    // offer one beat, hold it until taken
    task automatic send_beat(input logic [7:0] data, input logic present, input logic eos);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_data_byte     <= data;
        s_byte_present  <= present;
        s_end_of_stream <= eos;
        do @(posedge aclk); while (!s_ready);
        predict_beat(data, present, eos);
        beats_sent++;
    endtask

    task automatic send_pair(input logic [7:0] count, input logic [7:0] value, input logic eos);
        send_beat(count, 1'b1, 1'b0);
        send_beat(value, 1'b1, eos);
    endtask

    task automatic drain_results();
        int waited;
        @(negedge aclk);
        s_valid <= 1'b0;
        waited = 0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_words.size() != 0) begin
            report_mismatch("words still outstanding", 32'(expected_words.size()), 0);
            expected_words.delete();
        end
        // beats with no result may still be in the front end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_codec_mode(input logic mode);
        drain_results();
        @(negedge aclk);
        cfg_valid      <= 1'b1;
        cfg_codec_mode <= mode;
        do @(posedge aclk); while (!cfg_ready);
        pred_mode = mode;
        clear_stream_state();
        mode_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_compress_directed();
        set_codec_mode(MODE_ENCODE);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hA5, 1'b0, 1'b1);
        send_beat(8'h7E, 1'b1, 1'b1);
    endtask

    task automatic test_expand_directed();
        set_codec_mode(MODE_EXPAND);
        send_pair(8'd255, 8'hA5, 1'b0);
        send_pair(8'd8, 8'h11, 1'b0);
        send_pair(8'd9, 8'h22, 1'b0);
        send_pair(8'd1, 8'h00, 1'b1);
        // zero count, then a byte that must be ignored
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h44, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        // count left dangling at end, as its own beat and with the end
        send_beat(8'd3, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'd5, 1'b1, 1'b1);
        send_beat(8'h5A, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_mode_switch_mid_stream();
        set_codec_mode(MODE_ENCODE);
        send_beat(8'h11, 1'b1, 1'b0);
        send_beat(8'h11, 1'b1, 1'b0);
        set_codec_mode(MODE_EXPAND);
        send_pair(8'd2, 8'h33, 1'b1);
        send_beat(8'd4, 1'b1, 1'b0);
        set_codec_mode(MODE_ENCODE);
        send_beat(8'h44, 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        set_codec_mode(MODE_EXPAND);
        idle_on     = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        repeat (12) send_pair(8'($urandom_range(20, 40)), 8'($urandom_range(0, 255)), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_streams();
        int         phase_start;
        int         n;
        int         r;
        int         len;
        logic [7:0] val;
        logic [7:0] cnt;
        for (int ph = 0; ph < 4; ph++) begin
            set_codec_mode((ph % 2 == 0) ? MODE_EXPAND : MODE_ENCODE);
            phase_start = beats_sent;
            val         = 8'($urandom_range(0, 255));
            while (beats_sent - phase_start < 10) begin
                idle_on = ($urandom_range(0, 3) != 0);
                n       = $urandom_range(1, 5);
                if (pred_mode == MODE_EXPAND) begin
                    for (int p = 0; p < n; p++) begin
                        r = $urandom_range(0, 19);
                        if (r == 0) begin
                            send_beat(8'h00, 1'b1, 1'b0);
                            send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                        end else if (r == 1) begin
                            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                        end else begin
                            // mostly short runs, a few long ones
                            if (r == 2) cnt = 8'd255;
                            else if (r == 3) cnt = 8'($urandom_range(1, 255));
                            else cnt = 8'($urandom_range(1, 17));
                            send_pair(cnt, 8'($urandom_range(0, 255)), 1'b0);
                        end
                    end
                    r = $urandom_range(0, 5);
                    if (r == 0) begin
                        send_beat(8'($urandom_range(1, 255)), 1'b1, 1'b0);
                        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    end else if (r == 1) begin
                        send_beat(8'($urandom_range(1, 255)), 1'b1, 1'b1);
                    end else if (r <= 3) begin
                        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    end else begin
                        send_pair(8'($urandom_range(1, 17)), 8'($urandom_range(0, 255)), 1'b1);
                    end
                end else begin
                    for (int p = 0; p < n; p++) begin
                        r = $urandom_range(0, 7);
                        if (r == 0) val = 8'h00;
                        else if (r == 1) val = 8'hFF;
                        else if (r < 5) val = 8'($urandom_range(0, 255));
                        len = $urandom_range(1, 5);
                        repeat (len) send_beat(val, 1'b1, 1'b0);
                        if ($urandom_range(0, 7) == 0) begin
                            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                        end
                    end
                    // sometimes leave the run open into the next batch of runs
                    r = $urandom_range(0, 3);
                    if (r == 1) begin
                        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    end else if (r >= 2) begin
                        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                    end
                end
                if ($urandom_range(0, 4) == 0) begin
                    drain_results();
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // result sink: random ready gaps per word, plus a long hold-off on request
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_len > 0) begin
                gap         = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_valid || rx_hold_len > 0) break;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_w = {{m_lane7, m_lane6, m_lane5, m_lane4, m_lane3, m_lane2, m_lane1, m_lane0},
                     m_valid_bytes, m_last_of_item, m_stream_end, m_status};
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected result word", 0, 1);
            end else begin
                exp_w = expected_words.pop_front();
                for (int j = 0; j < 8; j++) begin
                    if (got_w.lanes[j] !== exp_w.lanes[j]) begin
                        report_mismatch($sformatf("lane%0d", j), 32'(exp_w.lanes[j]),
                                        32'(got_w.lanes[j]));
                    end
                end
                if (got_w.nbytes !== exp_w.nbytes)
                    report_mismatch("valid_bytes", 32'(exp_w.nbytes), 32'(got_w.nbytes));
                if (got_w.last !== exp_w.last)
                    report_mismatch("last_of_item", 32'(exp_w.last), 32'(got_w.last));
                if (got_w.send !== exp_w.send)
                    report_mismatch("stream_end", 32'(exp_w.send), 32'(got_w.send));
                if (got_w.stat !== exp_w.stat)
                    report_mismatch("status", 32'(exp_w.stat), 32'(got_w.stat));
            end
            results_seen++;
        end
    end

    initial begin
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_codec_mode  = MODE_ENCODE;
        s_valid         = 1'b0;
        s_data_byte     = 8'd0;
        s_byte_present  = 1'b0;
        s_end_of_stream = 1'b0;
        pred_mode       = MODE_ENCODE;
        clear_stream_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_compress_directed();
        test_expand_directed();
        test_mode_switch_mid_stream();
        test_backpressure();
        test_random_streams();
        drain_results();

        $display("covered %0d input beats, %0d result words, %0d mode writes",
                 beats_sent, results_seen, mode_writes);
        $display("both modes, zero and dangling counts, mode switches, long output hold-off");
        if (err_count == 0) begin
            $display("byte_run_length_codec_core regression: pass");
        end else begin
            $display("byte_run_length_codec_core regression: fail");
        end
        $finish;
    end

endmodule
